@@ rtl/core/bdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared constants and command types for the de Casteljau curve evaluator.
// ----------------------------------------------------------------------------
package bdc_pkg;

  localparam int MAX_POINTS = 32;
  localparam int COORD_BITS = 16;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int RES_W      = 3;
  localparam int IDX_W      = 7;
  localparam int WGT_W      = 7;
  // weight * coord, then sum of two such products
  localparam int PROD_W     = COORD_BITS + WGT_W + 1;
  localparam int SUM_W      = PROD_W + 1;

  localparam logic [RES_W-1:0] RES_MIN   = 3'd2;
  localparam logic [RES_W-1:0] RES_MAX   = 3'd6;
  localparam logic [RES_W-1:0] RES_RESET = 3'd4;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;

  typedef struct packed {
    logic              wr_ctrl;   // append beat into control store
    logic [ADDR_W-1:0] wr_addr;
    logic              load_k;    // latch sample index for an evaluate
    logic              zero_res;  // result forced to zero (too few points)
    logic              rd_en;
    logic              rd_scr;    // read scratch store instead of control store
    logic [ADDR_W-1:0] rd_addr;
    logic              lerp;      // this read pairs with the previous one
  } bdc_cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/bdc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdc_dp
// Datapath: control and scratch stores, three-stage lerp pipe, result regs.
// ----------------------------------------------------------------------------
module bdc_dp import bdc_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [RES_W-1:0]             cfg_data,
  input  wire logic signed [COORD_BITS-1:0] in_point_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_y,
  input  wire logic [IDX_W-1:0]             in_sample_index,
  input  wire bdc_cmd_t                     cmd,
  output logic signed [COORD_BITS-1:0]      res_x,
  output logic signed [COORD_BITS-1:0]      res_y
);

  logic [2*COORD_BITS-1:0] ctl_mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] scr_mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] ctl_rd_r;
  logic [2*COORD_BITS-1:0] scr_rd_r;

  logic [RES_W-1:0] res_log2_r;
  logic [WGT_W-1:0] wa_r, wb_r;

  logic              v1_r, lerp1_r, scr1_r;
  logic [ADDR_W-1:0] addr1_r;
  logic              v2_r;
  logic [ADDR_W-1:0] wa2_r;

  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic signed [PROD_W-1:0]     pax_r, pbx_r, pay_r, pby_r;
  logic signed [COORD_BITS-1:0] res_x_r, res_y_r;

  logic [RES_W-1:0]             cfg_sat;
  logic [WGT_W-1:0]             full, k_sat;
  logic [2*COORD_BITS-1:0]      cur;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic signed [COORD_BITS-1:0] lx, ly;

  // truncation toward zero of num / 2^s
  function automatic logic signed [COORD_BITS-1:0] div_trunc(
    input logic signed [PROD_W-1:0] pa,
    input logic signed [PROD_W-1:0] pb,
    input logic [RES_W-1:0]         s
  );
    logic signed [SUM_W-1:0] num;
    logic signed [SUM_W-1:0] bias;
    logic signed [SUM_W-1:0] q;
    num  = SUM_W'(pa) + SUM_W'(pb);
    bias = num[SUM_W-1] ? ((SUM_W'(1) <<< s) - SUM_W'(1)) : '0;
    q    = (num + bias) >>> s;
    return q[COORD_BITS-1:0];
  endfunction

  always_comb begin
    priority if (cfg_data < RES_MIN) cfg_sat = RES_MIN;
    else if (cfg_data > RES_MAX)     cfg_sat = RES_MAX;
    else                             cfg_sat = cfg_data;
  end

  assign full  = WGT_W'(1) << res_log2_r;
  assign k_sat = (in_sample_index > full) ? full : in_sample_index;

  assign cur   = scr1_r ? scr_rd_r : ctl_rd_r;
  assign cur_x = cur[2*COORD_BITS-1:COORD_BITS];
  assign cur_y = cur[COORD_BITS-1:0];

  assign lx = div_trunc(pax_r, pbx_r, res_log2_r);
  assign ly = div_trunc(pay_r, pby_r, res_log2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_log2_r <= RES_RESET;
    end else if (cfg_we) begin
      res_log2_r <= cfg_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_k) begin
      wa_r <= full - k_sat;
      wb_r <= k_sat;
    end
  end

  // control store
  always_ff @(posedge clk) begin
    if (cmd.wr_ctrl) begin
      ctl_mem[cmd.wr_addr] <= {in_point_x, in_point_y};
    end
    if (cmd.rd_en) begin
      ctl_rd_r <= ctl_mem[cmd.rd_addr];
    end
  end

  // scratch store
  always_ff @(posedge clk) begin
    if (v2_r) begin
      scr_mem[wa2_r] <= {lx, ly};
    end
    if (cmd.rd_en) begin
      scr_rd_r <= scr_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      lerp1_r <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      v1_r    <= cmd.rd_en;
      lerp1_r <= cmd.rd_en & cmd.lerp;
      v2_r    <= lerp1_r;
    end
  end

  always_ff @(posedge clk) begin
    scr1_r  <= cmd.rd_scr;
    addr1_r <= cmd.rd_addr;
    if (v1_r) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
    if (lerp1_r) begin
      pax_r <= PROD_W'(prev_x_r * $signed({1'b0, wa_r}));
      pbx_r <= PROD_W'(cur_x * $signed({1'b0, wb_r}));
      pay_r <= PROD_W'(prev_y_r * $signed({1'b0, wa_r}));
      pby_r <= PROD_W'(cur_y * $signed({1'b0, wb_r}));
      wa2_r <= addr1_r - ADDR_W'(1);
    end
  end

  // last value written is the curve point once the final round drains
  always_ff @(posedge clk) begin
    if (cmd.zero_res) begin
      res_x_r <= '0;
      res_y_r <= '0;
    end else if (v2_r) begin
      res_x_r <= lx;
      res_y_r <= ly;
    end
  end

  assign res_x = res_x_r;
  assign res_y = res_y_r;

endmodule
`default_nettype wire

@@ rtl/core/bdc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdc_ctrl
// Sequencer: point count, round and read index over the de Casteljau triangle.
// ----------------------------------------------------------------------------
module bdc_ctrl import bdc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_op,
  output logic            busy,
  output logic            done,
  output logic            status,
  output bdc_cmd_t        cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] m_r, m_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic              rnd1_r, rnd1_nxt;
  logic              drn_r, drn_nxt;
  logic              status_r, status_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    m_nxt      = m_r;
    j_nxt      = j_r;
    rnd1_nxt   = rnd1_r;
    drn_nxt    = drn_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.wr_addr = cnt_r[ADDR_W-1:0];
    cmd.rd_addr = j_r;
    cmd.rd_scr  = ~rnd1_r;
    cmd.lerp    = (j_r != '0);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_op)
            OP_APPEND: begin
              if (cnt_r < CNT_W'(MAX_POINTS)) begin
                cmd.wr_ctrl = 1'b1;
                cnt_nxt     = cnt_r + CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
            end
            OP_EVAL: begin
              cmd.load_k = 1'b1;
              if (cnt_r < CNT_W'(2)) begin
                cmd.zero_res = 1'b1;
                status_nxt   = 1'b1;
                state_nxt    = ST_DONE;
              end else begin
                status_nxt = 1'b0;
                m_nxt      = ADDR_W'(cnt_r - CNT_W'(1));
                j_nxt      = '0;
                rnd1_nxt   = 1'b1;
                state_nxt  = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        if (j_r == m_r) begin
          drn_nxt   = 1'b0;
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        // let the last write of the round land before reading it back
        if (drn_r) begin
          if (m_r == ADDR_W'(1)) begin
            state_nxt = ST_DONE;
          end else begin
            m_nxt     = m_r - ADDR_W'(1);
            j_nxt     = '0;
            rnd1_nxt  = 1'b0;
            state_nxt = ST_READ;
          end
        end else begin
          drn_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      m_r      <= '0;
      j_r      <= '0;
      rnd1_r   <= 1'b0;
      drn_r    <= 1'b0;
      status_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      m_r      <= m_nxt;
      j_r      <= j_nxt;
      rnd1_r   <= rnd1_nxt;
      drn_r    <= drn_nxt;
      status_r <= status_nxt;
    end
  end

  assign busy   = (state_r != ST_IDLE);
  assign done   = (state_r == ST_DONE);
  assign status = status_r;

endmodule
`default_nettype wire

@@ rtl/core/bezier_de_casteljau_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bezier_de_casteljau_eval
// Bezier curve sampler over a stored list of control points (de Casteljau).
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Append and clear finish
// in that cycle and busy stays low. An evaluate with n >= 2 stored points runs
// deg = n-1 rounds; each round of m lerps reads m+1 points one per cycle from
// a single-port store read and then waits in a drain state for its last write;
// busy stays high until the last cycle, in which out_valid is high. With fewer
// than two points out_valid comes in the cycle after the beat with status 1.
// out_valid is a one-cycle strobe and the receiver cannot stall it: take the
// result in that cycle.
module bezier_de_casteljau_eval import bdc_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_op,
  input  wire logic signed [COORD_BITS-1:0] in_point_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_y,
  input  wire logic [IDX_W-1:0]             in_sample_index,
  output logic                              out_valid,
  output logic signed [COORD_BITS-1:0]      out_curve_x,
  output logic signed [COORD_BITS-1:0]      out_curve_y,
  output logic                              out_status,
  input  wire logic                         cfg_we,
  input  wire logic [RES_W-1:0]             cfg_data
);

  bdc_cmd_t cmd;

  bdc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_op  (in_op),
    .busy   (busy),
    .done   (out_valid),
    .status (out_status),
    .cmd    (cmd)
  );

  bdc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_sample_index (in_sample_index),
    .cmd             (cmd),
    .res_x           (out_curve_x),
    .res_y           (out_curve_y)
  );

endmodule
`default_nettype wire
